// ===== rtl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the integer ALU
// Opcode codes, default data width and the sequencer state type.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DataWidthDef = 64;
    localparam int OpWidth      = 5;
    localparam int FieldWidth   = 64;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_TDIV = 5'd3,
        OP_TREM = 5'd4,
        OP_FDIV = 5'd5,
        OP_GCD  = 5'd6,
        OP_POW  = 5'd7,
        OP_AND  = 5'd8,
        OP_OR   = 5'd9,
        OP_XOR  = 5'd10,
        OP_SHL  = 5'd11,
        OP_SHR  = 5'd12,
        OP_MAX  = 5'd13,
        OP_MIN  = 5'd14,
        OP_SIGN = 5'd15,
        OP_ABS  = 5'd16,
        OP_NOT  = 5'd17,
        OP_MSB  = 5'd18,
        OP_PASS = 5'd19
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_GCD  = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

// ===== rtl/integer_alu_with_gcd_pow_unit.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_gcd_pow_unit: iterative signed integer ALU
// Add, sub, mul, div, rem, floor div, gcd, pow, logic, shifts, min/max etc.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one item: opcode, left and right
//   operands. Output channel o_valid/i_ready returns one result per item.
//   Only the low DATA_WIDTH bits of each operand count; the result is
//   sign-extended to 64 bits. One item at a time; after the item is
//   accepted, the sequencer runs:
//     simple opcodes, zero divisor, negative exponent: straight to S_FIN
//     multiply: W shift-add steps
//     div, rem, floor div: W restoring steps, then the sign fix-up
//     power: per exponent bit, LSB first, acc*base if the bit is set, then
//       base*base
//     gcd: Euclid, one full divide on the divide iterator per remainder;
//       about 90 remainders at most for 64 bits
//   Divide and gcd share a W-bit restoring subtract; multiply and power
//   share a W-bit shift-add. Reset clears the sequencer and output
//   valid. A result waits in the output register while i_ready is low;
//   o_ready stays low until the edge that takes the result.
module integer_alu_with_gcd_pow_unit #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ialu_pkg::OpWidth-1:0]        i_opcode,
    input  logic signed [ialu_pkg::FieldWidth-1:0] i_left_operand,
    input  logic signed [ialu_pkg::FieldWidth-1:0] i_right_operand,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ialu_pkg::FieldWidth-1:0] o_result
);
    import ialu_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    t_state         r_state, n_state;
    t_opcode        r_op, n_op;
    logic [W-1:0]   r_a, n_a;       // left operand / gcd x / pow base
    logic [W-1:0]   r_b, n_b;       // right operand / gcd y / pow exponent
    logic [W-1:0]   r_q, n_q;       // quotient / multiplier shift reg
    logic [W-1:0]   r_r, n_r;       // remainder / product accumulator
    logic [W-1:0]   r_m, n_m;       // multiplicand
    logic [W-1:0]   r_acc, n_acc;   // pow accumulator
    logic [W-1:0]   r_dd, n_dd;     // divisor magnitude
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [1:0]     r_mstep, n_mstep; // pow: 0 idle, 1 acc*base, 2 base*base
    logic [W-1:0]   r_res, n_res;
    logic           r_ovalid, n_ovalid;

    logic [W-1:0]   a_in, b_in;
    logic           a_neg, b_neg;
    logic [W-1:0]   simple;
    logic [5:0]     sh;
    logic [W:0]     trial;
    logic [W-1:0]   rsh;
    logic [W-1:0]   msb;

    assign a_in  = i_left_operand[W-1:0];
    assign b_in  = i_right_operand[W-1:0];
    assign a_neg = r_a[W-1];
    assign b_neg = r_b[W-1];
    assign sh    = r_b[5:0];

    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_result = FieldWidth'(signed'(r_res));

    // priority scan for msb index, positive operand only
    always_comb begin
        msb = '1;
        for (int i = 0; i < W; i++) begin
            if (r_a[i]) msb = W'(i);
        end
        if (a_neg) msb = W'(W - 1);
    end

    // combinational results for the simple opcodes
    always_comb begin
        rsh = '0;
        case (r_op)
            OP_SUB:  simple = r_a - r_b;
            OP_AND:  simple = r_a & r_b;
            OP_OR:   simple = r_a | r_b;
            OP_XOR:  simple = r_a ^ r_b;
            OP_SHL:  simple = (32'(sh) >= W) ? '0 : r_a << sh;
            OP_SHR: begin
                rsh    = (32'(sh) >= W) ? W'(W - 1) : W'(sh);
                simple = W'($signed(r_a) >>> rsh);
            end
            OP_MAX:  simple = ($signed(r_b) < $signed(r_a)) ? r_a : r_b;
            OP_MIN:  simple = ($signed(r_a) < $signed(r_b)) ? r_a : r_b;
            OP_SIGN: simple = a_neg ? '1 : ((r_a != '0) ? W'(1) : '0);
            OP_ABS:  simple = a_neg ? -r_a : r_a;
            OP_NOT:  simple = ~r_a;
            OP_MSB:  simple = msb;
            OP_PASS: simple = r_a;
            default: simple = r_a + r_b;
        endcase
    end

    // shared unit: restoring divide step on {r_r, r_q}
    assign trial = {r_r, r_q[W-1]} - {1'b0, r_dd};

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_q      = r_q;
        n_r      = r_r;
        n_m      = r_m;
        n_acc    = r_acc;
        n_dd     = r_dd;
        n_cnt    = r_cnt;
        n_mstep  = r_mstep;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_op    = t_opcode'(i_opcode);
                    n_a     = a_in;
                    n_b     = b_in;
                    n_state = S_FIN;
                    case (t_opcode'(i_opcode))
                        OP_TDIV, OP_TREM, OP_FDIV: begin
                            n_q     = a_in[W-1] ? -a_in : a_in;
                            n_dd    = b_in[W-1] ? -b_in : b_in;
                            n_r     = '0;
                            n_cnt   = CW'(W);
                            n_state = (b_in == '0) ? S_FIN : S_DIV;
                        end
                        OP_GCD: begin
                            n_a     = a_in[W-1] ? -a_in : a_in;
                            n_b     = b_in[W-1] ? -b_in : b_in;
                            n_state = S_GCD;
                        end
                        OP_MUL: begin
                            n_q     = b_in;
                            n_m     = a_in;
                            n_r     = '0;
                            n_cnt   = CW'(W);
                            n_mstep = 2'd0;
                            n_state = S_MUL;
                        end
                        OP_POW: begin
                            n_acc   = W'(1);
                            n_mstep = 2'd1;
                            n_cnt   = '0;
                            n_state = b_in[W-1] ? S_FIN : S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                if (!trial[W]) begin
                    n_r = trial[W-1:0];
                    n_q = {r_q[W-2:0], 1'b1};
                end else begin
                    n_r = {r_r[W-2:0], r_q[W-1]};
                    n_q = {r_q[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = (r_op == OP_GCD) ? S_GCD : S_FIN;
                end
            end
            S_GCD: begin
                // r_a = x, r_b = y; after a divide r_r holds x mod y
                if (r_cnt == '0 && r_dd == r_b && r_mstep == 2'd3) begin
                    n_a     = r_b;
                    n_b     = r_r;
                    n_mstep = 2'd0;
                end else if (r_b == '0) begin
                    n_res    = r_a;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_q     = r_a;
                    n_dd    = r_b;
                    n_r     = '0;
                    n_cnt   = CW'(W);
                    n_mstep = 2'd3;
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                if (r_op == OP_POW && r_cnt == '0) begin
                    // pow sequencer: load the next product
                    if (r_mstep == 2'd1) begin
                        if (r_b == '0) begin
                            n_res    = r_acc;
                            n_ovalid = 1'b1;
                            n_state  = S_IDLE;
                        end else if (r_b[0]) begin
                            n_q = r_acc; n_m = r_a; n_r = '0;
                            n_cnt = CW'(W);
                        end else begin
                            n_mstep = 2'd2;
                        end
                    end else begin
                        n_q = r_a; n_m = r_a; n_r = '0;
                        n_cnt = CW'(W);
                    end
                end else begin
                    // shift-add step: MSB first
                    n_r   = (r_r << 1) + (r_q[W-1] ? r_m : '0);
                    n_q   = r_q << 1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        if (r_op == OP_POW) begin
                            if (r_mstep == 2'd1) begin
                                n_acc   = n_r;
                                n_mstep = 2'd2;
                            end else begin
                                n_a     = n_r;
                                n_b     = r_b >> 1;
                                n_mstep = 2'd1;
                            end
                        end else begin
                            n_res    = n_r;
                            n_ovalid = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end
            S_FIN: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
                case (r_op)
                    OP_TDIV, OP_FDIV: begin
                        if (r_b == '0) begin
                            n_res = '0;
                        end else begin
                            n_res = (a_neg != b_neg) ? -r_q : r_q;
                            if (r_op == OP_FDIV && a_neg != b_neg && r_r != '0)
                                n_res = -r_q - 1'b1;
                        end
                    end
                    OP_TREM: n_res = (r_b == '0) ? '0 : (a_neg ? -r_r : r_r);
                    OP_POW:  n_res = W'(1);
                    default: n_res = simple;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_mstep  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_mstep  <= n_mstep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_q   <= n_q;
        r_r   <= n_r;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_dd  <= n_dd;
        r_res <= n_res;
    end

endmodule
